// ----- sv/tgm_pkg.sv -----
`timescale 1ns / 1ps
// package for the thresholded gradient magnitude unit
// holds register indexes, opcodes, field widths, reset values and the config struct

package tgm_pkg;

	// default sizes handed down as top level parameters
	localparam int DEF_MAX_ROWS   = 256;
	localparam int DEF_MAX_COLS   = 256;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int DEF_FRAC_BITS  = 4;

	// fixed field widths
	localparam int COORD_W    = 8;
	localparam int PIX_IN_W   = 16;
	localparam int CUT_W      = 16;
	localparam int SIZE_W     = 9;
	localparam int RESULT_W   = 21;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_ABOVE_CUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BELOW_CUT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_ON = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 3'd4;

	// opcodes carried in s_tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// reset values of the config registers
	localparam logic [SIZE_W-1:0] RST_ROWS_IN_USE = 9'd256;
	localparam logic [SIZE_W-1:0] RST_COLS_IN_USE = 9'd256;

	typedef struct packed {
		logic [CUT_W-1:0]  above_cut;
		logic [CUT_W-1:0]  below_cut;
		logic              gradient_on;
		logic [SIZE_W-1:0] rows_in_use;
		logic [SIZE_W-1:0] cols_in_use;
	} cfg_t;

endpackage

// ----- sv/tgm_ram.sv -----
`timescale 1ns / 1ps
// generic single port ram with registered read data
// no dependencies

module tgm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read on the same address, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- sv/tgm_isqrt.sv -----
`timescale 1ns / 1ps
// iterative floor square root, one result bit per cycle
// no dependencies

module tgm_isqrt #(
	parameter int ROOT_W = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   operand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int OP_W  = 2 * ROOT_W;
	localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OP_W-1:0]   opnd_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+1:0] rem_shift;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	// bring down two operand bits and try root*4+1
	always_comb begin
		rem_shift = {rem_q[ROOT_W-1:0], opnd_q[OP_W-1 -: 2]};
		trial     = {root_q, 2'b01};
		fits      = (rem_shift >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= opnd_q << 2;
			if (fits) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- sv/tgm_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer and datapath: pixel cuts, neighbor fetch, shared squarer, root hand-off
// depends on tgm_pkg; drives one tgm_ram and one tgm_isqrt

module tgm_ctrl import tgm_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	localparam int ADDR_W    = $clog2(MAX_ROWS * MAX_COLS),
	localparam int ACC_W     = 2 * PIXEL_BITS + 1,
	localparam int ROOT_W    = (ACC_W + 2 * FRAC_BITS + 1) / 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	// input beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tuser,
	// frame store
	output logic                  ram_we,
	output logic [ADDR_W-1:0]     ram_addr,
	output logic [PIXEL_BITS-1:0] ram_wdata,
	input  logic [PIXEL_BITS-1:0] ram_rdata,
	// square root unit
	output logic                  root_start,
	output logic [2*ROOT_W-1:0]   root_operand,
	input  logic                  root_done,
	input  logic [ROOT_W-1:0]     root_value
);

	localparam int PIX_W  = PIXEL_BITS;
	localparam int OP_W   = 2 * ROOT_W;
	localparam int SH_W   = PIX_W + FRAC_BITS;
	localparam int CMP_W  = (PIX_W > CUT_W) ? PIX_W : CUT_W;
	localparam int RDIM_W = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
	localparam int CDIM_W = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RD_HI,
		ST_RD_LO,
		ST_CAP_LO,
		ST_SQR,
		ST_ACC,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_PIX,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [COORD_W-1:0]     row_q;
	logic [COORD_W-1:0]     col_q;
	logic [PIX_IN_W-1:0]    pix_q;
	logic                   dir_q;
	logic [PIX_W-1:0]       hi_q;
	logic [PIX_W-1:0]       lo_q;
	logic [2*PIX_W-1:0]     prod_q;
	logic [ACC_W-1:0]       acc_q;
	logic [RESULT_W-1:0]    res_q;
	logic                   bad_q;
	logic                   m_tvalid_q;
	logic [RESULT_W-1:0]    m_result_q;
	logic                   m_bad_q;

	logic [RDIM_W-1:0]      rows_ext, nr, r_ext, r_hi, r_lo, r_sel;
	logic [CDIM_W-1:0]      cols_ext, nc, c_ext, c_hi, c_lo, c_sel;
	logic                   in_frame;
	logic [PIX_W-1:0]       pix_pb;
	logic [CMP_W-1:0]       pix_cmp, above_cmp, below_cmp;
	logic                   cut_zero;
	logic [PIX_W:0]         diff;
	logic [PIX_W-1:0]       mag;

	// frame size saturated to 2..max, and the in-frame test
	always_comb begin
		rows_ext = RDIM_W'(cfg.rows_in_use);
		cols_ext = CDIM_W'(cfg.cols_in_use);
		if (rows_ext < RDIM_W'(2))             nr = RDIM_W'(2);
		else if (rows_ext > RDIM_W'(MAX_ROWS)) nr = RDIM_W'(MAX_ROWS);
		else                                   nr = rows_ext;
		if (cols_ext < CDIM_W'(2))             nc = CDIM_W'(2);
		else if (cols_ext > CDIM_W'(MAX_COLS)) nc = CDIM_W'(MAX_COLS);
		else                                   nc = cols_ext;
		r_ext    = RDIM_W'(row_q);
		c_ext    = CDIM_W'(col_q);
		in_frame = (r_ext < nr) && (c_ext < nc);
	end

	// neighbor coordinates, one-sided on the frame border
	always_comb begin
		r_hi = (r_ext == nr - RDIM_W'(1)) ? r_ext : r_ext + RDIM_W'(1);
		r_lo = (r_ext == '0) ? r_ext : r_ext - RDIM_W'(1);
		c_hi = (c_ext == nc - CDIM_W'(1)) ? c_ext : c_ext + CDIM_W'(1);
		c_lo = (c_ext == '0) ? c_ext : c_ext - CDIM_W'(1);
		r_sel = r_ext;
		c_sel = c_ext;
		if (state_q == ST_RD_HI) begin
			if (dir_q) c_sel = c_hi;
			else       r_sel = r_hi;
		end else if (state_q == ST_RD_LO) begin
			if (dir_q) c_sel = c_lo;
			else       r_sel = r_lo;
		end
		ram_addr = ADDR_W'(r_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(c_sel);
	end

	// pixel cuts on the write path
	always_comb begin
		pix_pb    = PIX_W'(pix_q);
		pix_cmp   = CMP_W'(pix_pb);
		above_cmp = CMP_W'(cfg.above_cut);
		below_cmp = CMP_W'(cfg.below_cut);
		cut_zero  = ((cfg.above_cut != '0) && (pix_cmp > above_cmp)) ||
		            ((cfg.below_cut != '0) && (pix_cmp <= below_cmp));
		ram_we    = (state_q == ST_CHECK) && (op_q == OP_WRITE) && in_frame;
		ram_wdata = cut_zero ? '0 : pix_pb;
	end

	// magnitude of the difference feeding the squarer
	always_comb begin
		diff = {1'b0, hi_q} - {1'b0, lo_q};
		mag  = diff[PIX_W] ? PIX_W'(-diff) : PIX_W'(diff);
	end

	assign root_start   = (state_q == ST_ROOT_GO);
	assign root_operand = OP_W'(acc_q) << (2 * FRAC_BITS);

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			dir_q      <= 1'b0;
		end else begin
			// a finished item loads the result beat, m_tready drains it
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					dir_q <= 1'b0;
					if (op_q == OP_WRITE)  state_q <= ST_IDLE;
					else if (!in_frame)    state_q <= ST_DONE;
					else if (cfg.gradient_on) state_q <= ST_RD_HI;
					else                   state_q <= ST_PIX;
				end
				ST_RD_HI:  state_q <= ST_RD_LO;
				ST_RD_LO:  state_q <= ST_CAP_LO;
				ST_CAP_LO: state_q <= ST_SQR;
				ST_SQR:    state_q <= ST_ACC;
				ST_ACC: begin
					if (dir_q) begin
						state_q <= ST_ROOT_GO;
					end else begin
						dir_q   <= 1'b1;
						state_q <= ST_RD_HI;
					end
				end
				ST_ROOT_GO: state_q <= ST_ROOT_WAIT;
				ST_ROOT_WAIT: begin
					if (root_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_PIX: state_q <= ST_DONE;
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= s_tuser;
				row_q <= s_tdata[COORD_W-1:0];
				col_q <= s_tdata[2*COORD_W-1:COORD_W];
				pix_q <= s_tdata[2*COORD_W +: PIX_IN_W];
			end
			ST_CHECK: begin
				acc_q <= '0;
				res_q <= '0;
				bad_q <= !in_frame;
			end
			ST_RD_LO:  hi_q <= ram_rdata;
			ST_CAP_LO: lo_q <= ram_rdata;
			ST_SQR:    prod_q <= (2*PIX_W)'(mag) * (2*PIX_W)'(mag);
			ST_ACC:    acc_q <= acc_q + ACC_W'(prod_q);
			ST_ROOT_WAIT: res_q <= RESULT_W'(root_value);
			ST_PIX:    res_q <= RESULT_W'(SH_W'(ram_rdata) << FRAC_BITS);
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_result_q <= res_q;
					m_bad_q    <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_result_q);
	assign m_tuser  = m_bad_q;

endmodule

// ----- sv/thresholded_gradient_magnitude_unit.sv -----
`timescale 1ns / 1ps
// top level: config registers, frame store, sequencer and square root unit
// depends on tgm_pkg, tgm_ram, tgm_isqrt, tgm_ctrl
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata {pixel_value, col, row}, tuser opcode
//  m_*      out        m_tvalid/m_tready  tdata result_value, tuser bad_coord
//  cfg_*    in         cfg_we             cfg_index, cfg_wdata
//
// a write beat is accepted, then the cut pixel goes into the store when in frame.
// a read with gradient off passes ST_CHECK, ST_PIX and ST_DONE; out of frame reads skip ST_PIX.
// a gradient read does four store reads through the single ram port, two passes of the
// squarer, then one root bit per cycle.
// reset clears the sequencer and config registers; the frame store is not cleared.
// a result waiting on m_tready stalls the next read only at its final load.

module thresholded_gradient_magnitude_unit import tgm_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // row[7:0], col[15:8], pixel_value[31:16]
	input  logic                  s_tuser,   // opcode
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // result_value[20:0], zero[23:21]
	output logic                  m_tuser    // bad_coord
);

	localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
	localparam int ACC_W  = 2 * PIXEL_BITS + 1;
	localparam int ROOT_W = (ACC_W + 2 * FRAC_BITS + 1) / 2;

	cfg_t                  cfg_q;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_addr;
	logic [PIXEL_BITS-1:0] ram_wdata;
	logic [PIXEL_BITS-1:0] ram_rdata;
	logic                  root_start;
	logic [2*ROOT_W-1:0]   root_operand;
	logic                  root_done;
	logic [ROOT_W-1:0]     root_value;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.above_cut   <= '0;
			cfg_q.below_cut   <= '0;
			cfg_q.gradient_on <= 1'b1;
			cfg_q.rows_in_use <= RST_ROWS_IN_USE;
			cfg_q.cols_in_use <= RST_COLS_IN_USE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ABOVE_CUT:   cfg_q.above_cut   <= cfg_wdata[CUT_W-1:0];
				REG_BELOW_CUT:   cfg_q.below_cut   <= cfg_wdata[CUT_W-1:0];
				REG_GRADIENT_ON: cfg_q.gradient_on <= cfg_wdata[0];
				REG_ROWS_IN_USE: cfg_q.rows_in_use <= cfg_wdata[SIZE_W-1:0];
				REG_COLS_IN_USE: cfg_q.cols_in_use <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame store
	tgm_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_ROWS * MAX_COLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// square root unit
	tgm_isqrt #(
		.ROOT_W (ROOT_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (root_operand),
		.done    (root_done),
		.root    (root_value)
	);

	// sequencer
	tgm_ctrl #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.ram_we       (ram_we),
		.ram_addr     (ram_addr),
		.ram_wdata    (ram_wdata),
		.ram_rdata    (ram_rdata),
		.root_start   (root_start),
		.root_operand (root_operand),
		.root_done    (root_done),
		.root_value   (root_value)
	);

endmodule
